// ===== hw/rtl/pwrwd_pkg.sv =====
// pwrwd_pkg: types, codes and helpers shared by the power-button watchdog
// used by the channel interfaces, pwrwd_step and power_button_watchdog_fsm
// no dependencies
package pwrwd_pkg;

  // field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned TickW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // register reset values
  localparam logic [TickW-1:0] InitTimeoutRst   = 8'd5;
  localparam logic [TickW-1:0] ActiveTimeoutRst = 8'd10;
  localparam logic [TickW-1:0] TickMax          = 8'd255;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_INIT_TIMEOUT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_TIMEOUT = 2'd1;

  // event kinds
  localparam logic [OpW-1:0] OP_TICK    = 2'd0;
  localparam logic [OpW-1:0] OP_SENSE_A = 2'd1;
  localparam logic [OpW-1:0] OP_SENSE_B = 2'd2;
  localparam logic [OpW-1:0] OP_CMD     = 2'd3;

  // commands
  localparam logic [CmdW-1:0] CMD_GET_STATE = 3'd0;
  localparam logic [CmdW-1:0] CMD_TOUCH     = 3'd1;
  localparam logic [CmdW-1:0] CMD_SHUTDOWN  = 3'd2;
  localparam logic [CmdW-1:0] CMD_HARD_RST  = 3'd3;
  localparam logic [CmdW-1:0] CMD_POWER_UP  = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_ON  = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_OFF = 2'd2;
  localparam logic [StatusW-1:0] ST_UNKNOWN = 2'd3;

  // external mode codes
  localparam logic [ModeW-1:0] CODE_INIT     = 3'd0;
  localparam logic [ModeW-1:0] CODE_OFF      = 3'd1;
  localparam logic [ModeW-1:0] CODE_PWRUP    = 3'd2;
  localparam logic [ModeW-1:0] CODE_ON       = 3'd3;
  localparam logic [ModeW-1:0] CODE_ACTIVE   = 3'd4;
  localparam logic [ModeW-1:0] CODE_SHUTDOWN = 3'd5;
  localparam logic [ModeW-1:0] CODE_RESET    = 3'd6;

  // watchdog state, one-hot
  typedef enum logic [6:0] {
    MODE_INIT     = 7'b0000001,
    MODE_OFF      = 7'b0000010,
    MODE_PWRUP    = 7'b0000100,
    MODE_ON       = 7'b0001000,
    MODE_ACTIVE   = 7'b0010000,
    MODE_SHUTDOWN = 7'b0100000,
    MODE_RESET    = 7'b1000000
  } mode_e;

  // one input item
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic            pin_level;
    logic [CmdW-1:0] command;
  } item_t;

  // one result item
  typedef struct packed {
    logic [ModeW-1:0]   current_mode;
    logic               power_drive;
    logic               entered;
    logic [StatusW-1:0] status;
  } res_t;

  // next state and outcome of one step
  typedef struct packed {
    mode_e              mode;
    logic [TickW-1:0]   elapsed;
    logic               drive;
    logic               entered;
    logic [StatusW-1:0] status;
  } step_t;

  // one-hot state to external code
  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] code;
    case (m)
      MODE_INIT:     code = CODE_INIT;
      MODE_OFF:      code = CODE_OFF;
      MODE_PWRUP:    code = CODE_PWRUP;
      MODE_ON:       code = CODE_ON;
      MODE_ACTIVE:   code = CODE_ACTIVE;
      MODE_SHUTDOWN: code = CODE_SHUTDOWN;
      MODE_RESET:    code = CODE_RESET;
      default:       code = CODE_INIT;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/pwrwd_in_if.sv =====
// pwrwd_in_if: input event channel of the power-button watchdog
// depends on pwrwd_pkg
interface pwrwd_in_if;
  logic                           valid;
  logic                           ready;
  logic [pwrwd_pkg::OpW-1:0]      op;
  logic                           pin_level;
  logic [pwrwd_pkg::CmdW-1:0]     command;

  modport source (output valid, op, pin_level, command, input ready);
  modport sink   (input valid, op, pin_level, command, output ready);
endinterface

// ===== hw/rtl/pwrwd_out_if.sv =====
// pwrwd_out_if: result channel of the power-button watchdog
// depends on pwrwd_pkg
interface pwrwd_out_if;
  logic                           valid;
  logic                           ready;
  logic [pwrwd_pkg::ModeW-1:0]    current_mode;
  logic                           power_drive;
  logic                           entered;
  logic [pwrwd_pkg::StatusW-1:0]  status;

  modport source (output valid, current_mode, power_drive, entered, status, input ready);
  modport sink   (input valid, current_mode, power_drive, entered, status, output ready);
endinterface

// ===== hw/rtl/pwrwd_cfg_if.sv =====
// pwrwd_cfg_if: register write channel of the power-button watchdog
// depends on pwrwd_pkg
interface pwrwd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pwrwd_pkg::CfgIdxW-1:0]   index;
  logic [pwrwd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pwrwd_step.sv =====
// pwrwd_step: transition logic of the watchdog for one event
// depends on pwrwd_pkg; purely combinational, used by power_button_watchdog_fsm
module pwrwd_step (
  input  pwrwd_pkg::mode_e                 mode_i,
  input  logic [pwrwd_pkg::TickW-1:0]      elapsed_i,
  input  logic                             drive_i,
  input  pwrwd_pkg::item_t                 item_i,
  input  logic [pwrwd_pkg::TickW-1:0]      init_timeout_i,
  input  logic [pwrwd_pkg::TickW-1:0]      active_timeout_i,
  output pwrwd_pkg::step_t                 step_o
);

  logic [pwrwd_pkg::TickW-1:0] tick_inc;
  logic [pwrwd_pkg::TickW-1:0] limit;
  logic                        on_like;
  logic                        react_a;
  logic                        do_enter;
  pwrwd_pkg::mode_e            target;
  logic                        drive_pre;

  // saturating tick count and timeout limit of the current state
  assign tick_inc = (elapsed_i == pwrwd_pkg::TickMax) ? elapsed_i
                                                      : elapsed_i + 1'b1;
  always_comb begin
    case (mode_i)
      pwrwd_pkg::MODE_INIT:   limit = init_timeout_i;
      pwrwd_pkg::MODE_ACTIVE: limit = active_timeout_i;
      default:                limit = '0;
    endcase
  end

  assign on_like = (mode_i == pwrwd_pkg::MODE_ON) || (mode_i == pwrwd_pkg::MODE_ACTIVE);

  // early states react to a high first sense input, the rest to a low one
  assign react_a = (mode_i == pwrwd_pkg::MODE_INIT || mode_i == pwrwd_pkg::MODE_OFF ||
                    mode_i == pwrwd_pkg::MODE_PWRUP) ? item_i.pin_level
                                                     : !item_i.pin_level;

  // event decode: pick the target state and status
  always_comb begin
    do_enter       = 1'b0;
    target         = mode_i;
    drive_pre      = drive_i;
    step_o.elapsed = elapsed_i;
    step_o.status  = pwrwd_pkg::ST_OK;
    case (item_i.op)
      pwrwd_pkg::OP_TICK: begin
        step_o.elapsed = tick_inc;
        if (limit != '0 && limit <= tick_inc) begin
          do_enter = 1'b1;
          target   = (mode_i == pwrwd_pkg::MODE_INIT) ? pwrwd_pkg::MODE_PWRUP
                                                      : pwrwd_pkg::MODE_RESET;
        end
      end
      pwrwd_pkg::OP_SENSE_A: begin
        if (react_a) begin
          do_enter = 1'b1;
          case (mode_i)
            pwrwd_pkg::MODE_INIT,
            pwrwd_pkg::MODE_OFF:      target = pwrwd_pkg::MODE_ON;
            pwrwd_pkg::MODE_PWRUP: begin
              target    = pwrwd_pkg::MODE_ON;
              drive_pre = 1'b0;
            end
            pwrwd_pkg::MODE_ON:       target = pwrwd_pkg::MODE_OFF;
            pwrwd_pkg::MODE_ACTIVE:   target = pwrwd_pkg::MODE_SHUTDOWN;
            pwrwd_pkg::MODE_SHUTDOWN: begin
              target    = pwrwd_pkg::MODE_OFF;
              drive_pre = 1'b0;
            end
            pwrwd_pkg::MODE_RESET: begin
              target    = pwrwd_pkg::MODE_INIT;
              drive_pre = 1'b0;
            end
            default:                  target = mode_i;
          endcase
        end
      end
      pwrwd_pkg::OP_SENSE_B: begin
        if (!item_i.pin_level &&
            (mode_i == pwrwd_pkg::MODE_INIT || mode_i == pwrwd_pkg::MODE_OFF)) begin
          do_enter = 1'b1;
          target   = pwrwd_pkg::MODE_INIT;
        end
      end
      default: begin
        case (item_i.command)
          pwrwd_pkg::CMD_GET_STATE: ;
          pwrwd_pkg::CMD_TOUCH,
          pwrwd_pkg::CMD_SHUTDOWN,
          pwrwd_pkg::CMD_HARD_RST: begin
            if (!on_like) begin
              step_o.status = pwrwd_pkg::ST_NOT_ON;
            end else begin
              do_enter = 1'b1;
              if (item_i.command == pwrwd_pkg::CMD_TOUCH) begin
                target = pwrwd_pkg::MODE_ACTIVE;
              end else if (item_i.command == pwrwd_pkg::CMD_SHUTDOWN) begin
                target = pwrwd_pkg::MODE_SHUTDOWN;
              end else begin
                target = pwrwd_pkg::MODE_RESET;
              end
            end
          end
          pwrwd_pkg::CMD_POWER_UP: begin
            if (mode_i == pwrwd_pkg::MODE_INIT || mode_i == pwrwd_pkg::MODE_OFF ||
                mode_i == pwrwd_pkg::MODE_PWRUP) begin
              do_enter = 1'b1;
              target   = pwrwd_pkg::MODE_PWRUP;
            end else begin
              step_o.status = pwrwd_pkg::ST_NOT_OFF;
            end
          end
          default: step_o.status = pwrwd_pkg::ST_UNKNOWN;
        endcase
      end
    endcase

    // state entry: clear the count and apply the entry drive action
    step_o.mode    = mode_i;
    step_o.drive   = drive_pre;
    step_o.entered = do_enter;
    if (do_enter) begin
      step_o.mode    = target;
      step_o.elapsed = '0;
      case (target)
        pwrwd_pkg::MODE_INIT,
        pwrwd_pkg::MODE_OFF:      step_o.drive = 1'b0;
        pwrwd_pkg::MODE_PWRUP,
        pwrwd_pkg::MODE_SHUTDOWN,
        pwrwd_pkg::MODE_RESET:    step_o.drive = 1'b1;
        default:                  step_o.drive = drive_pre;
      endcase
    end
  end

endmodule

// ===== hw/rtl/power_button_watchdog_fsm.sv =====
// power_button_watchdog_fsm: top level of the power-button watchdog
// depends on pwrwd_pkg, pwrwd_in_if, pwrwd_out_if, pwrwd_cfg_if and pwrwd_step
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   op, pin_level, command
//   res_o    out  valid/ready   current_mode, power_drive, entered, status
//   cfg_i    in   valid/ready   index, data (init_timeout, active_timeout)
//
// one event per cycle while results are taken: an event is held in an input
// register, one level of transition logic updates the state and loads the
// result register once the output is free
// the input register refills in the cycle it drains, so a stalled result
// holds both registers and throttles in_i.ready
// reset: state init, drive released, timeouts 5 and 10; cfg_i is always ready
module power_button_watchdog_fsm (
  input  logic        clk_i,
  input  logic        rst_ni,
  pwrwd_in_if.sink    in_i,
  pwrwd_out_if.source res_o,
  pwrwd_cfg_if.sink   cfg_i
);

  logic                        in_valid_q;
  pwrwd_pkg::item_t            in_q;
  logic                        res_valid_q;
  pwrwd_pkg::res_t             res_q;
  pwrwd_pkg::mode_e            mode_q;
  logic [pwrwd_pkg::TickW-1:0] elapsed_q;
  logic                        drive_q;
  logic [pwrwd_pkg::TickW-1:0] init_timeout_q;
  logic [pwrwd_pkg::TickW-1:0] active_timeout_q;
  logic                        out_free;
  logic                        advance;
  pwrwd_pkg::step_t            step;

  // flow control
  assign out_free    = !res_valid_q || res_o.ready;
  assign advance     = in_valid_q && out_free;
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_timeout_q   <= pwrwd_pkg::InitTimeoutRst;
      active_timeout_q <= pwrwd_pkg::ActiveTimeoutRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pwrwd_pkg::CFG_INIT_TIMEOUT:   init_timeout_q   <= cfg_i.data;
        pwrwd_pkg::CFG_ACTIVE_TIMEOUT: active_timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.op        <= in_i.op;
      in_q.pin_level <= in_i.pin_level;
      in_q.command   <= in_i.command;
    end
  end

  pwrwd_step u_step (
    .mode_i           (mode_q),
    .elapsed_i        (elapsed_q),
    .drive_i          (drive_q),
    .item_i           (in_q),
    .init_timeout_i   (init_timeout_q),
    .active_timeout_i (active_timeout_q),
    .step_o           (step)
  );

  // watchdog state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= pwrwd_pkg::MODE_INIT;
      elapsed_q <= '0;
      drive_q   <= 1'b0;
    end else if (advance) begin
      mode_q    <= step.mode;
      elapsed_q <= step.elapsed;
      drive_q   <= step.drive;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.current_mode <= pwrwd_pkg::mode_code(step.mode);
      res_q.power_drive  <= step.drive;
      res_q.entered      <= step.entered;
      res_q.status       <= step.status;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.current_mode = res_q.current_mode;
  assign res_o.power_drive  = res_q.power_drive;
  assign res_o.entered      = res_q.entered;
  assign res_o.status       = res_q.status;

  // a state entry always restarts the tick count
  a_entry_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step.entered |=> elapsed_q == '0)
    else $error("tick count not cleared on state entry");

  // pressing states hold the drive, released states keep it off
  a_drive_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == pwrwd_pkg::MODE_PWRUP || mode_q == pwrwd_pkg::MODE_SHUTDOWN ||
     mode_q == pwrwd_pkg::MODE_RESET) |-> drive_q)
    else $error("drive released in a pressing state");

  a_drive_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == pwrwd_pkg::MODE_INIT || mode_q == pwrwd_pkg::MODE_OFF) |-> !drive_q)
    else $error("drive pressed in a released state");

  // every drained event leaves a result behind
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("event drained without a result");

  // a rejected command never enters a state
  a_status_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status != pwrwd_pkg::ST_OK |-> !res_q.entered)
    else $error("state entered on a rejected command");

endmodule

// ===== test/power_button_watchdog_fsm_tb.sv =====
// power_button_watchdog_fsm_tb: self-checking bench for the power-button watchdog
// holds its own watchdog predictor and scoreboard class; needs pwrwd_pkg and the
// pwrwd_in_if, pwrwd_out_if and pwrwd_cfg_if channels
`timescale 1ns / 100ps

package pwrwd_check_pkg;
  import pwrwd_pkg::*;

  // which sense level a state reacts to
  typedef enum logic [1:0] {
    SENSE_DEAF,
    SENSE_HIGH,
    SENSE_LOW
  } sense_e;

  class watchdog_sb;
    logic [ModeW-1:0] cur_mode;
    logic [TickW-1:0] elapsed;
    logic             drive;
    logic [TickW-1:0] init_limit;
    logic [TickW-1:0] active_limit;
    res_t             pending_reports[$];
    int unsigned      faults;

    function new();
      init_limit   = InitTimeoutRst;
      active_limit = ActiveTimeoutRst;
      drive        = 1'b0;
      faults       = 0;
      enter_mode(CODE_INIT);
    endfunction

    // state entry clears the count and sets the drive where the state says so
    function void enter_mode(logic [ModeW-1:0] m);
      cur_mode = m;
      elapsed  = '0;
      case (m)
        CODE_INIT, CODE_OFF: drive = 1'b0;
        CODE_PWRUP, CODE_SHUTDOWN, CODE_RESET: drive = 1'b1;
        default: ;
      endcase
    endfunction

    function bit hits(sense_e s, logic lvl);
      return (s == SENSE_HIGH && lvl) || (s == SENSE_LOW && !lvl);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_INIT_TIMEOUT) init_limit = val;
      else if (idx == CFG_ACTIVE_TIMEOUT) active_limit = val;
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    // step the watchdog for one accepted event and queue the report it gives
    function void predict_event(item_t it);
      sense_e           lvl_a, lvl_b;
      logic [ModeW-1:0] to_tmo, to_a, to_b;
      logic             drop_a;
      logic [TickW-1:0] limit;
      logic             ent;
      logic [StatusW-1:0] st;
      res_t             rep;
      lvl_a  = SENSE_DEAF;
      lvl_b  = SENSE_DEAF;
      to_tmo = CODE_INIT;
      to_a   = CODE_INIT;
      to_b   = CODE_INIT;
      drop_a = 1'b0;
      limit  = '0;
      ent    = 1'b0;
      st     = ST_OK;
      // transition table row of the current state
      case (cur_mode)
        CODE_INIT: begin
          lvl_a = SENSE_HIGH; lvl_b = SENSE_LOW;
          to_tmo = CODE_PWRUP; to_a = CODE_ON; to_b = CODE_INIT;
          limit = init_limit;
        end
        CODE_OFF: begin
          lvl_a = SENSE_HIGH; lvl_b = SENSE_LOW;
          to_a = CODE_ON; to_b = CODE_INIT;
        end
        CODE_PWRUP: begin
          lvl_a = SENSE_HIGH; to_a = CODE_ON; drop_a = 1'b1;
        end
        CODE_ON: begin
          lvl_a = SENSE_LOW; to_a = CODE_OFF;
        end
        CODE_ACTIVE: begin
          lvl_a = SENSE_LOW; to_a = CODE_SHUTDOWN; to_tmo = CODE_RESET;
          limit = active_limit;
        end
        CODE_SHUTDOWN: begin
          lvl_a = SENSE_LOW; to_a = CODE_OFF; drop_a = 1'b1;
        end
        CODE_RESET: begin
          lvl_a = SENSE_LOW; to_a = CODE_INIT; drop_a = 1'b1;
        end
        default: ;
      endcase
      case (it.op)
        OP_TICK: begin
          // saturating count, timeout fires once the count reaches the limit
          if (elapsed != TickMax) elapsed = elapsed + 1'b1;
          if (limit != '0 && elapsed >= limit) begin
            enter_mode(to_tmo);
            ent = 1'b1;
          end
        end
        OP_SENSE_A: begin
          if (hits(lvl_a, it.pin_level)) begin
            if (drop_a) drive = 1'b0;
            enter_mode(to_a);
            ent = 1'b1;
          end
        end
        OP_SENSE_B: begin
          if (hits(lvl_b, it.pin_level)) begin
            enter_mode(to_b);
            ent = 1'b1;
          end
        end
        default: begin
          case (it.command)
            CMD_GET_STATE: ;
            CMD_TOUCH, CMD_SHUTDOWN, CMD_HARD_RST: begin
              if (cur_mode != CODE_ON && cur_mode != CODE_ACTIVE) begin
                st = ST_NOT_ON;
              end else begin
                enter_mode(it.command == CMD_TOUCH ? CODE_ACTIVE :
                           it.command == CMD_SHUTDOWN ? CODE_SHUTDOWN : CODE_RESET);
                ent = 1'b1;
              end
            end
            CMD_POWER_UP: begin
              if (cur_mode >= CODE_ON) begin
                st = ST_NOT_OFF;
              end else begin
                enter_mode(CODE_PWRUP);
                ent = 1'b1;
              end
            end
            default: st = ST_UNKNOWN;
          endcase
        end
      endcase
      rep.current_mode = cur_mode;
      rep.power_drive  = drive;
      rep.entered      = ent;
      rep.status       = st;
      pending_reports.push_back(rep);
    endfunction

    // compare one report against the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (pending_reports.size() == 0) begin
        note_fault($sformatf("unexpected result: mode %0d drive %0b entered %0b status %0d",
                             got.current_mode, got.power_drive, got.entered, got.status));
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want)
        note_fault($sformatf({"result mismatch: expected mode %0d drive %0b entered %0b ",
                              "status %0d, got mode %0d drive %0b entered %0b status %0d"},
                             want.current_mode, want.power_drive, want.entered, want.status,
                             got.current_mode, got.power_drive, got.entered, got.status));
    endfunction
  endclass
endpackage

module power_button_watchdog_fsm_tb;
  import pwrwd_pkg::*;
  import pwrwd_check_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  pwrwd_in_if  ev_ch ();
  pwrwd_out_if res_ch ();
  pwrwd_cfg_if cfg_ch ();

  power_button_watchdog_fsm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  watchdog_sb  sb;
  int unsigned burst_left;
  int unsigned gap_max;

  function automatic item_t ev(logic [OpW-1:0] op, logic lvl, logic [CmdW-1:0] cmd);
    item_t it;
    it.op        = op;
    it.pin_level = lvl;
    it.command   = cmd;
    return it;
  endfunction

  // random event, ticks weighted by tick_pct, mostly known commands
  function automatic item_t rand_item(int unsigned tick_pct);
    item_t it;
    it.op = ($urandom_range(99) < tick_pct) ? OP_TICK : OpW'($urandom_range(OP_CMD, OP_SENSE_A));
    it.pin_level = 1'($urandom_range(1));
    it.command = ($urandom_range(3) == 0) ? CmdW'($urandom_range((1 << CmdW) - 1))
                                          : CmdW'($urandom_range(CMD_POWER_UP));
    return it;
  endfunction

  // one event transfer, sent in bursts with random gaps between them
  task automatic send_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap != 0) begin
        ev_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    ev_ch.valid     <= 1'b1;
    ev_ch.op        <= it.op;
    ev_ch.pin_level <= it.pin_level;
    ev_ch.command   <= it.command;
    @(posedge clk_i);
    while (!ev_ch.ready) @(posedge clk_i);
    sb.predict_event(it);
  endtask

  // hold off the sender until every predicted report has come back
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    ev_ch.valid <= 1'b0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0) sb.note_fault("results still outstanding at drain");
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  // both timeout registers, back to back on the config channel
  task automatic set_limits(input logic [CfgDataW-1:0] init_v, input logic [CfgDataW-1:0] act_v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_INIT_TIMEOUT;
    cfg_ch.data  <= init_v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_reg(CFG_INIT_TIMEOUT, init_v);
    cfg_ch.index <= CFG_ACTIVE_TIMEOUT;
    cfg_ch.data  <= act_v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_reg(CFG_ACTIVE_TIMEOUT, act_v);
    cfg_ch.valid <= 1'b0;
  endtask

  // reaches active from any state: two low senses settle in init, off or pwrup,
  // power up, high sense to on, touch to active
  task automatic bring_to_active();
    send_item(ev(OP_SENSE_A, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_SENSE_A, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_CMD, 1'b0, CMD_POWER_UP));
    send_item(ev(OP_SENSE_A, 1'b1, CMD_GET_STATE));
    send_item(ev(OP_CMD, 1'b0, CMD_TOUCH));
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] init_v, input logic [CfgDataW-1:0] act_v,
                           input int unsigned count, input int unsigned tick_pct,
                           input int unsigned gmax);
    drain_results();
    set_limits(init_v, act_v);
    gap_max = gmax;
    repeat (count) begin
      if ($urandom_range(99) < 8) bring_to_active();
      else send_item(rand_item(tick_pct));
    end
  endtask

  // result sink with its own stall pattern, checks every report transfer
  initial begin : result_sink
    int unsigned stall_pct;
    int unsigned stall_run;
    res_t        seen;
    stall_pct = 0;
    stall_run = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        seen.current_mode = res_ch.current_mode;
        seen.power_drive  = res_ch.power_drive;
        seen.entered      = res_ch.entered;
        seen.status       = res_ch.status;
        sb.check_result(seen);
      end
      if (stall_run == 0) begin
        stall_run = $urandom_range(200, 20);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_run--;
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // main sequence
  initial begin
    sb = new();
    ev_ch.valid     <= 1'b0;
    ev_ch.op        <= OP_TICK;
    ev_ch.pin_level <= 1'b0;
    ev_ch.command   <= CMD_GET_STATE;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_INIT_TIMEOUT;
    cfg_ch.data     <= '0;
    burst_left = 0;
    gap_max    = 3;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // commands refused in init, unknown commands
    send_item(ev(OP_CMD, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_CMD, 1'b1, CMD_TOUCH));
    send_item(ev(OP_CMD, 1'b0, CMD_SHUTDOWN));
    send_item(ev(OP_CMD, 1'b1, CMD_HARD_RST));
    for (int c = CMD_POWER_UP + 1; c < (1 << CmdW); c++)
      send_item(ev(OP_CMD, 1'b0, CmdW'(c)));
    // ignored senses, second sense re-enters init
    send_item(ev(OP_SENSE_A, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_SENSE_B, 1'b1, CMD_GET_STATE));
    send_item(ev(OP_SENSE_B, 1'b0, CMD_GET_STATE));
    // init timeout at its reset value
    repeat (5) send_item(ev(OP_TICK, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_SENSE_B, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_CMD, 1'b0, CMD_POWER_UP));
    send_item(ev(OP_SENSE_A, 1'b1, CMD_GET_STATE));
    send_item(ev(OP_TICK, 1'b1, CMD_GET_STATE));
    send_item(ev(OP_CMD, 1'b0, CMD_POWER_UP));
    // touch twice re-enters active, then shutdown path
    send_item(ev(OP_CMD, 1'b0, CMD_TOUCH));
    send_item(ev(OP_CMD, 1'b0, CMD_TOUCH));
    send_item(ev(OP_CMD, 1'b0, CMD_SHUTDOWN));
    send_item(ev(OP_SENSE_A, 1'b1, CMD_GET_STATE));
    send_item(ev(OP_SENSE_A, 1'b0, CMD_GET_STATE));
    // hard reset path back to init
    send_item(ev(OP_SENSE_B, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_SENSE_A, 1'b1, CMD_GET_STATE));
    send_item(ev(OP_CMD, 1'b0, CMD_HARD_RST));
    send_item(ev(OP_SENSE_A, 1'b0, CMD_GET_STATE));

    // random phases over several timeout settings
    run_phase(8'd1, 8'd1, 20, 50, 4);
    run_phase('0, '0, 20, 30, 0);
    run_phase(8'd2, 8'd3, 20, 60, 8);
    run_phase(CfgDataW'($urandom_range(20, 1)), CfgDataW'($urandom_range(20, 1)), 20, 45, 3);
    run_phase(TickMax, TickMax, 20, 40, 2);

    // count saturation: park in active with timeouts off, then raise the
    // limit to the top, the very next tick must fire
    drain_results();
    set_limits('0, '0);
    gap_max = 0;
    bring_to_active();
    repeat (300) send_item(ev(OP_TICK, 1'b0, CMD_GET_STATE));
    drain_results();
    set_limits(TickMax, TickMax);
    gap_max = 2;
    send_item(ev(OP_TICK, 1'b0, CMD_GET_STATE));
    send_item(ev(OP_SENSE_A, 1'b0, CMD_GET_STATE));

    run_phase(InitTimeoutRst, ActiveTimeoutRst, 20, 55, 5);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.faults == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // watchdog on the run itself
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
